@@ rtl/vna_pkg.sv @@
// vna_pkg: shared types and constants for the vertex normal accumulator
// used by vna_datapath and vertex_normal_accumulator
`timescale 1ns / 1ps

package vna_pkg;

  localparam int unsigned MaxVertices = 256;
  localparam int unsigned AccW = 48;
  localparam int unsigned PosW = 16;
  localparam int unsigned NrmW = 16;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_MUL,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_NRD,
    ST_NMAG,
    ST_NSHIFT,
    ST_NSQ,
    ST_NSQRT,
    ST_NDIV,
    ST_OUT
  } state_e;

  // saturating 48-bit signed add
  function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a,
                                              input logic [AccW-1:0] b);
    logic [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) begin
      sat_add = s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      sat_add = s[AccW-1:0];
    end
  endfunction

endpackage

@@ rtl/vna_datapath.sv @@
// vna_datapath: memories, sequencer and shared arithmetic unit
// depends on vna_pkg
`timescale 1ns / 1ps

module vna_datapath #(
  parameter int unsigned MaxVerts = vna_pkg::MaxVertices
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  vna_pkg::req_e        req_i,
  input  logic [47:0]          pos_i,
  input  logic [7:0]           ia_i,
  input  logic [7:0]           ib_i,
  input  logic [7:0]           ic_i,
  input  logic [8:0]           vcount_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [47:0]          res_o,
  output logic                 status_o
);
  import vna_pkg::*;

  // an 8-bit index never reaches past 256 entries
  localparam int unsigned Depth = (MaxVerts < 256) ? MaxVerts : 256;
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  state_e state_q, state_d;

  // memories
  logic [47:0]     pos_mem [Depth];
  logic [3*AccW-1:0] acc_mem [Depth];
  logic [3*AccW-1:0] acc_rd_q;
  logic [47:0]     pos_rd_q;
  logic [Depth-1:0] acc_vld_q;

  logic [IdxW-1:0] pos_addr, acc_addr;
  logic            pos_we, acc_we;
  logic [3*AccW-1:0] acc_wdata;

  // request registers
  req_e            req_q;
  logic [IdxW-1:0] ia_q, ib_q, ic_q;
  logic [47:0]     posw_q;
  logic            status_q;
  logic [1:0]      cnt_q, cnt_d;
  logic [5:0]      it_q, it_d;

  // triangle regs
  logic signed [16:0] e1_q [3];
  logic signed [16:0] e2_q [3];
  logic signed [15:0] pa_q [3];
  logic signed [33:0] prod_q;
  logic signed [33:0] mul_p_prev;
  logic signed [34:0] cr_q [3];

  // normalise regs
  logic [47:0] mag_q [3];
  logic        neg_q [3];
  logic [29:0] m_q [3];
  logic [63:0] s_q, root_q, rem_q;
  logic [63:0] bit_q;
  logic [44:0] num_q;
  logic [31:0] len_q;
  logic [15:0] q_q;
  logic [15:0] nout_q [3];
  logic [47:0] big;
  logic [5:0]  msb;

  function automatic logic valid(input logic [7:0] i, input logic [8:0] vc);
    valid = ({1'b0, i} < vc) && ({24'd0, i} < 32'(MaxVerts));
  endfunction

  logic ok_w, ok_t, ok_r;
  assign ok_w = valid(ia_i, vcount_i);
  assign ok_t = valid(ia_i, vcount_i) && valid(ib_i, vcount_i) && valid(ic_i, vcount_i);
  assign ok_r = ok_w;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    it_d    = it_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (req_i)
            REQ_WRITE: state_d = ST_OUT;
            REQ_CLEAR: state_d = ST_OUT;
            REQ_ADD:   state_d = ok_t ? ST_RDA : ST_OUT;
            REQ_READ:  state_d = ok_r ? ST_NRD : ST_OUT;
            default:   state_d = ST_OUT;
          endcase
        end
      end
      ST_RDA: state_d = ST_RDB;
      ST_RDB: state_d = ST_RDC;
      ST_RDC: begin
        state_d = ST_MUL;
        it_d = '0;
      end
      ST_MUL: begin
        it_d = it_q + 6'd1;
        if (it_q == 6'd7) begin
          state_d = ST_ACC_RD;
          cnt_d = '0;
        end
      end
      ST_ACC_RD: state_d = ST_ACC_WR;
      ST_ACC_WR: begin
        cnt_d = cnt_q + 2'd1;
        state_d = (cnt_q == 2'd2) ? ST_OUT : ST_ACC_RD;
      end
      ST_NRD: state_d = ST_NMAG;
      ST_NMAG: state_d = ST_NSHIFT;
      ST_NSHIFT: begin
        // zero accumulator reads back as a zero normal
        state_d = (big == '0) ? ST_OUT : ST_NSQ;
        it_d = '0;
      end
      ST_NSQ: begin
        it_d = it_q + 6'd1;
        if (it_q == 6'd2) begin
          state_d = ST_NSQRT;
          it_d = '0;
        end
      end
      ST_NSQRT: begin
        it_d = it_q + 6'd1;
        if (it_q == 6'd31) begin
          state_d = ST_NDIV;
          it_d = '0;
          cnt_d = '0;
        end
      end
      ST_NDIV: begin
        it_d = it_q + 6'd1;
        if (it_q == 6'd15) begin
          it_d = '0;
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd2) state_d = ST_OUT;
        end
      end
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      it_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      it_q <= it_d;
    end
  end

  // outputs
  always_comb begin
    busy_o = (state_q != ST_IDLE);
    done_o = (state_q == ST_OUT);
  end

  // memory addressing
  always_comb begin
    pos_addr = ia_q;
    acc_addr = ia_q;
    pos_we = 1'b0;
    acc_we = 1'b0;
    unique case (state_q)
      ST_RDB: pos_addr = ib_q;
      ST_RDC: pos_addr = ic_q;
      default: pos_addr = ia_q;
    endcase
    if (state_q == ST_ACC_RD || state_q == ST_ACC_WR) begin
      unique case (cnt_q)
        2'd0: acc_addr = ia_q;
        2'd1: acc_addr = ib_q;
        default: acc_addr = ic_q;
      endcase
    end
    if (state_q == ST_ACC_WR) acc_we = 1'b1;
    if (state_q == ST_OUT && req_q == REQ_WRITE && !status_q) pos_we = 1'b1;
  end

  logic [AccW-1:0] ax, ay, az;
  assign ax = acc_rd_q[AccW-1:0];
  assign ay = acc_rd_q[2*AccW-1:AccW];
  assign az = acc_rd_q[3*AccW-1:2*AccW];
  assign acc_wdata = {sat_add(az, AccW'(cr_q[2])), sat_add(ay, AccW'(cr_q[1])),
                      sat_add(ax, AccW'(cr_q[0]))};

  // position memory
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_addr] <= posw_q;
    pos_rd_q <= pos_mem[pos_addr];
  end

  // accumulator memory, invalid entries read as zero
  logic acc_rd_vld;
  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_addr] <= acc_wdata;
    acc_rd_q <= acc_rd_vld ? acc_mem[acc_addr] : '0;
  end
  assign acc_rd_vld = acc_vld_q[acc_addr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
    end else if (state_q == ST_OUT && req_q == REQ_CLEAR) begin
      acc_vld_q <= '0;
    end else if (acc_we) begin
      acc_vld_q[acc_addr] <= 1'b1;
    end
  end

  // request capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= 1'b0;
      req_q <= REQ_WRITE;
    end else if (start_i && state_q == ST_IDLE) begin
      req_q <= req_i;
      unique case (req_i)
        REQ_ADD: status_q <= !ok_t;
        REQ_CLEAR: status_q <= 1'b0;
        default: status_q <= !ok_w;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == ST_IDLE) begin
      ia_q <= IdxW'(ia_i);
      ib_q <= IdxW'(ib_i);
      ic_q <= IdxW'(ic_i);
      posw_q <= pos_i;
    end
  end

  // shared multiplier operands
  // the edge e2 is registered on step zero of ST_MUL, so products run on steps one to six
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;
  logic [29:0] sq_op;
  logic [59:0] sq_p;
  assign mul_p = mul_a * mul_b;
  assign sq_p = sq_op * sq_op;
  always_comb begin
    mul_a = e1_q[1];
    mul_b = e2_q[2];
    unique case (it_q[2:0])
      3'd1: begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
      3'd2: begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
      3'd3: begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
      3'd4: begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
      3'd5: begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
      default: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
    endcase
    unique case (it_q[1:0])
      2'd0: sq_op = m_q[0];
      2'd1: sq_op = m_q[1];
      default: sq_op = m_q[2];
    endcase
  end

  // triangle datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RDB) begin
      pa_q[0] <= pos_rd_q[15:0];
      pa_q[1] <= pos_rd_q[31:16];
      pa_q[2] <= pos_rd_q[47:32];
    end
    if (state_q == ST_RDC) begin
      e1_q[0] <= 17'($signed(pos_rd_q[15:0])) - 17'(pa_q[0]);
      e1_q[1] <= 17'($signed(pos_rd_q[31:16])) - 17'(pa_q[1]);
      e1_q[2] <= 17'($signed(pos_rd_q[47:32])) - 17'(pa_q[2]);
    end
    if (state_q == ST_MUL && it_q == 6'd0) begin
      e2_q[0] <= 17'($signed(pos_rd_q[15:0])) - 17'(pa_q[0]);
      e2_q[1] <= 17'($signed(pos_rd_q[31:16])) - 17'(pa_q[1]);
      e2_q[2] <= 17'($signed(pos_rd_q[47:32])) - 17'(pa_q[2]);
    end
    if (state_q == ST_MUL) begin
      // each pair of products folded on the step after the pair
      unique case (it_q[2:0])
        3'd3: cr_q[0] <= 35'(prod_q) - 35'(mul_p_prev);
        3'd5: cr_q[1] <= 35'(prod_q) - 35'(mul_p_prev);
        3'd7: cr_q[2] <= 35'(prod_q) - 35'(mul_p_prev);
        default: ;
      endcase
    end
  end

  // product pipeline: prod_q holds the odd-step term, mul_p_prev the even one
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      if (it_q[0]) prod_q <= mul_p;
      else mul_p_prev <= mul_p;
    end
  end

  // normalise datapath
  always_comb begin
    big = mag_q[0];
    if (mag_q[1] > big) big = mag_q[1];
    if (mag_q[2] > big) big = mag_q[2];
    msb = '0;
    for (int b = 0; b < 48; b++) begin
      if (big[b]) msb = 6'(b);
    end
  end

  // one square root step per cycle
  logic [63:0] sq_rem, sq_try, root_nx;
  logic        sq_ge;
  always_comb begin
    sq_rem = (it_q == 6'd0) ? s_q : rem_q;
    sq_try = root_q + bit_q;
    sq_ge = sq_rem >= sq_try;
    root_nx = sq_ge ? (root_q >> 1) + bit_q : root_q >> 1;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_NMAG) begin
      mag_q[0] <= ax[AccW-1] ? 48'(-ax) : ax;
      mag_q[1] <= ay[AccW-1] ? 48'(-ay) : ay;
      mag_q[2] <= az[AccW-1] ? 48'(-az) : az;
      neg_q[0] <= ax[AccW-1];
      neg_q[1] <= ay[AccW-1];
      neg_q[2] <= az[AccW-1];
    end
    if (state_q == ST_NSHIFT) begin
      for (int k = 0; k < 3; k++) begin
        if (msb >= 6'd29) m_q[k] <= 30'(mag_q[k] >> (msb - 6'd29));
        else m_q[k] <= 30'(mag_q[k] << (6'd29 - msb));
      end
      s_q <= '0;
    end
    if (state_q == ST_NSQ) begin
      s_q <= s_q + 64'(sq_p);
      root_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end
    if (state_q == ST_NSQRT) begin
      rem_q <= sq_ge ? sq_rem - sq_try : sq_rem;
      root_q <= root_nx;
      bit_q <= bit_q >> 2;
      if (it_q == 6'd31) len_q <= root_nx[31:0];
    end
    if (state_q == ST_NDIV) begin
      if (it_q == 6'd0) begin
        num_q <= {15'd0, (cnt_q == 2'd0 ? m_q[0] : cnt_q == 2'd1 ? m_q[1] : m_q[2])}
                 * 45'd16384 + 45'(len_q >> 1);
      end
    end
  end

  assign res_o = {nout_q[2], nout_q[1], nout_q[0]};
  assign status_o = status_q;

  // quotient bits from bit 14 down, one trial multiply per step: num / len,
  // len in [2^29, 2^31), quotient at most 16384
  logic [15:0] div_q;
  logic [15:0] q_trial;
  logic [47:0] div_prod;
  logic        div_fit;
  assign q_trial = q_q | (16'd1 << (4'd15 - it_q[3:0]));
  assign div_prod = 48'(q_trial) * 48'(len_q);
  assign div_fit = div_prod <= 48'(num_q);
  assign div_q = div_fit ? q_trial : q_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_NDIV) begin
      if (it_q == 6'd0) q_q <= '0;
      else if (div_fit) q_q <= q_trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nout_q[0] <= '0;
      nout_q[1] <= '0;
      nout_q[2] <= '0;
    end else if (start_i && state_q == ST_IDLE) begin
      nout_q[0] <= '0;
      nout_q[1] <= '0;
      nout_q[2] <= '0;
    end else if (state_q == ST_NDIV && it_q == 6'd15) begin
      unique case (cnt_q)
        2'd0: nout_q[0] <= neg_q[0] ? 16'(-div_q) : div_q;
        2'd1: nout_q[1] <= neg_q[1] ? 16'(-div_q) : div_q;
        default: nout_q[2] <= neg_q[2] ? 16'(-div_q) : div_q;
      endcase
    end
  end

endmodule

@@ rtl/vertex_normal_accumulator.sv @@
// vertex_normal_accumulator: top level, stream ports and result register
// depends on vna_pkg and vna_datapath
`timescale 1ns / 1ps

// channel | direction | payload
// s_axis  | in        | tdata: pos_x, pos_y, pos_z, index_a, index_b, index_c; tuser: req_type
// m_axis  | out       | tdata: normal_x, normal_y, normal_z, status
// cfg     | in        | vertex_count
// from accepted transfer to result valid: write, clear and rejected requests go straight
// to the result state; add runs eight multiply steps and three read-modify-writes, read
// a square root of 32 steps and three 16-step divides, read of a zero accumulator skips
// both. rst_ni clears the sequencer and the accumulator valid bits. the block takes no
// transfer until the result is taken.

module vertex_normal_accumulator #(
  parameter int unsigned MAX_VERTICES = vna_pkg::MaxVertices
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // pos_x, pos_y, pos_z, index_a, index_b, index_c
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // normal_x, normal_y, normal_z, status, pad
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);
  import vna_pkg::*;

  logic [8:0]  vcount_q;
  logic        busy, done, status;
  logic [47:0] res;
  logic        out_vld_q;
  logic [48:0] out_q;
  logic        start;

  assign start = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy && !out_vld_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vcount_q <= '0;
    else if (cfg_we_i) vcount_q <= cfg_wdata_i;
  end

  vna_datapath #(.MaxVerts(MAX_VERTICES)) u_dp (
    .clk_i, .rst_ni,
    .start_i (start),
    .req_i   (req_e'(s_axis_tuser)),
    .pos_i   (s_axis_tdata[47:0]),
    .ia_i    (s_axis_tdata[55:48]),
    .ib_i    (s_axis_tdata[63:56]),
    .ic_i    (s_axis_tdata[71:64]),
    .vcount_i(vcount_q),
    .busy_o  (busy),
    .done_o  (done),
    .res_o   (res),
    .status_o(status)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (done) out_vld_q <= 1'b1;
    else if (m_axis_tready) out_vld_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (done) out_q <= {status, res};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = {7'd0, out_q};

endmodule
